FILE: rtl/core/lfgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfgr_pkg
// Shared types and constants of the linear fade gain ramp.
// ----------------------------------------------------------------------------
package lfgr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int NARROW_W    = 8;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int GAIN_SHIFT  = 10;
    localparam int DIV_STEPS   = GAIN_SHIFT + 1;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int PROD_W      = DIV_STEPS + 1 + SAMPLE_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_IN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_SAMPLES = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic mul;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/core/lfgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfgr_ctrl
// Sequencer: takes one item, runs the shared divider, multiply and output.
// ----------------------------------------------------------------------------
module lfgr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lfgr_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output lfgr_pkg::t_cmd o_cmd
);

    lfgr_pkg::t_state r_state;
    lfgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfgr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lfgr_pkg::ST_PREP;
                end
            end
            lfgr_pkg::ST_PREP: begin
                n_state = lfgr_pkg::ST_DIV;
            end
            lfgr_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = lfgr_pkg::ST_MUL;
                end
            end
            lfgr_pkg::ST_MUL: begin
                n_state = lfgr_pkg::ST_FIN;
            end
            lfgr_pkg::ST_FIN: begin
                if (!i_sts.out_busy) begin
                    n_state = lfgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lfgr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            lfgr_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            lfgr_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            lfgr_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            lfgr_pkg::ST_FIN: begin
                o_cmd.fin = !i_sts.out_busy;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfgr_pkg::ST_MUL) |->
        ($past(r_state) == lfgr_pkg::ST_DIV && $past(i_sts.div_done)))
        else $error("multiply entered before divide finished");
`endif

endmodule

FILE: rtl/core/lfgr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfgr_dp
// Datapath: position counter, restoring divider, gain multiply, output stage.
// ----------------------------------------------------------------------------
module lfgr_dp #(
    parameter int MAX_FADE_LENGTH = 1048576
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lfgr_pkg::t_cmd                     i_cmd,
    output lfgr_pkg::t_sts                     o_sts,
    input  logic [$clog2(MAX_FADE_LENGTH+1)-1:0] i_len,
    input  logic                               i_fade_in,
    input  logic                               i_wide,
    input  logic signed [lfgr_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [lfgr_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                               o_run_last
);

    localparam int LW = $clog2(MAX_FADE_LENGTH + 1);
    localparam int PW = $clog2(MAX_FADE_LENGTH);
    localparam int QB = lfgr_pkg::DIV_STEPS;
    localparam int DW = LW + lfgr_pkg::GAIN_SHIFT;
    localparam int SW = lfgr_pkg::SAMPLE_W;
    localparam int NW = lfgr_pkg::NARROW_W;
    localparam int RW = lfgr_pkg::PROD_W;

    logic [PW-1:0]                   r_position;
    logic signed [SW-1:0]            r_sample;
    logic                            r_last;
    logic [LW-1:0]                   r_mult;
    logic [LW-1:0]                   r_rem;
    logic [QB-1:0]                   r_quo;
    logic [lfgr_pkg::CNT_W-1:0]      r_cnt;
    logic signed [RW-1:0]            r_prod;
    logic                            r_out_valid;
    logic signed [SW-1:0]            r_sample_out;
    logic                            r_run_last;

    logic [LW-1:0]                   w_pos_ext;
    logic                            w_last;
    logic [LW-1:0]                   w_idx;
    logic [LW-1:0]                   w_mult;
    logic [NW-1:0]                   w_mag;
    logic [LW+NW-1:0]                w_prod_n;
    logic [DW-1:0]                   w_dividend;
    logic [LW:0]                     w_trial;
    logic                            w_ge;
    logic signed [QB:0]              w_gain;
    logic signed [RW-1:0]            w_adj;
    logic signed [SW-1:0]            w_wide_res;
    logic signed [SW-1:0]            w_narrow_res;

    // position and multiplier for the accepted item
    assign w_pos_ext = LW'(r_position);
    assign w_last    = (w_pos_ext >= (i_len - LW'(1)));
    assign w_idx     = w_last ? (i_len - LW'(1)) : w_pos_ext;
    assign w_mult    = i_fade_in ? w_idx : (i_len - w_idx);

    // magnitude of the narrow sample
    assign w_mag      = r_sample[NW-1] ? NW'(~r_sample[NW-1:0] + NW'(1)) : r_sample[NW-1:0];
    assign w_prod_n   = r_mult * w_mag;
    assign w_dividend = i_wide ? {r_mult, {lfgr_pkg::GAIN_SHIFT{1'b0}}} : DW'(w_prod_n);

    // restoring divide step
    assign w_trial = {r_rem, r_quo[QB-1]};
    assign w_ge    = (w_trial >= {1'b0, i_len});

    // truncate toward zero
    assign w_gain       = $signed({1'b0, r_quo});
    assign w_adj        = r_prod + RW'({lfgr_pkg::GAIN_SHIFT{r_prod[RW-1]}});
    assign w_wide_res   = w_adj[lfgr_pkg::GAIN_SHIFT+SW-1:lfgr_pkg::GAIN_SHIFT];
    assign w_narrow_res = r_sample[NW-1] ? SW'(SW'(0) - SW'(r_quo)) : SW'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_position <= w_last ? '0 : (r_position + PW'(1));
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_in;
            r_last   <= w_last;
            r_mult   <= w_mult;
        end
        if (i_cmd.prep) begin
            r_rem <= LW'(w_dividend[DW-1:QB]);
            r_quo <= w_dividend[QB-1:0];
            r_cnt <= lfgr_pkg::CNT_W'(QB - 1);
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? LW'(w_trial - {1'b0, i_len}) : LW'(w_trial);
            r_quo <= {r_quo[QB-2:0], w_ge};
            r_cnt <= r_cnt - lfgr_pkg::CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= w_gain * r_sample;
        end
        if (i_cmd.fin) begin
            r_sample_out <= i_wide ? w_wide_res : w_narrow_res;
            r_run_last   <= r_last;
        end
    end

    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_busy = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_sample_out;
    assign o_run_last     = r_run_last;

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= PW'(MAX_FADE_LENGTH - 1))
        else $error("position beyond maximum run length");
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < i_len))
        else $error("divider remainder not below length");
    a_wide_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && i_wide) |-> (r_quo <= QB'(1 << lfgr_pkg::GAIN_SHIFT)))
        else $error("gain above unity");
    a_narrow_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && !i_wide) |-> (r_quo <= QB'(1 << (NW - 1))))
        else $error("narrow quotient out of range");
`endif

endmodule

FILE: rtl/core/linear_fade_gain_ramp.sv
`timescale 1ns / 1ps
// an accepted item passes prep, the divider steps, multiply and finish before its result is registered
// one item at a time: the input stalls while an item runs the 11-step shared restoring divider
// a new item is taken while the previous result waits in the output register
// reset (synchronous, active low): position 0, length 1, fade-in, 16-bit samples
// ----------------------------------------------------------------------------
// linear_fade_gain_ramp
// Linear fade-in or fade-out gain applied to a run of signed samples.
// ----------------------------------------------------------------------------
module linear_fade_gain_ramp #(
    parameter int MAX_FADE_LENGTH = 1048576
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [lfgr_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [lfgr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [lfgr_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [lfgr_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                                    o_run_last
);

    localparam int LW = $clog2(MAX_FADE_LENGTH + 1);
    localparam int CW = (LW > lfgr_pkg::CFG_DATA_W) ? LW : lfgr_pkg::CFG_DATA_W;

    logic [LW-1:0]  r_len;
    logic           r_fade_in;
    logic           r_wide;
    logic [CW-1:0]  w_len_raw;
    logic [CW-1:0]  w_len_clamp;

    lfgr_pkg::t_cmd w_cmd;
    lfgr_pkg::t_sts w_sts;

    // zero acts as one, above maximum acts as maximum
    assign w_len_raw   = CW'(i_cfg_data);
    assign w_len_clamp = (w_len_raw == '0) ? CW'(1) :
                         (w_len_raw > CW'(MAX_FADE_LENGTH)) ? CW'(MAX_FADE_LENGTH) :
                         w_len_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LW'(1);
            r_fade_in <= 1'b1;
            r_wide    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfgr_pkg::CFG_FADE_LENGTH: begin
                    r_len <= LW'(w_len_clamp);
                end
                lfgr_pkg::CFG_FADE_IN: begin
                    r_fade_in <= i_cfg_data[0];
                end
                lfgr_pkg::CFG_WIDE_SAMPLES: begin
                    r_wide <= i_cfg_data[0];
                end
                default: begin
                    r_len <= r_len;
                end
            endcase
        end
    end

    lfgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    lfgr_dp #(
        .MAX_FADE_LENGTH (MAX_FADE_LENGTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_len        (r_len),
        .i_fade_in    (r_fade_in),
        .i_wide       (r_wide),
        .i_sample_in  (i_sample_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_run_last   (o_run_last)
    );

endmodule

FILE: dv/tb_linear_fade_gain_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_fade_gain_ramp
// Self-checking bench for the linear fade gain ramp. A scoreboard class keeps
// its own copy of the run position and the fade registers, predicts every
// faded sample when a sample item is taken, and compares each result item in
// order. A short directed part covers the extremes of the samples and the
// registers, zero and oversized lengths, a length cut below the position and
// 8-bit mode with out-of-range samples. Random phases follow, each with a new
// configuration. Idling runs receiver-heavy, then sender-heavy, then off.
// ----------------------------------------------------------------------------
module tb_linear_fade_gain_ramp;

    localparam int     MAX_LEN         = 1048576;
    localparam int     ITEMS_PER_PHASE = 112;
    localparam int     NUM_PHASES      = 9;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint GAIN_ONE        = longint'(1) << lfgr_pkg::GAIN_SHIFT;

    typedef struct {
        logic signed [lfgr_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
    } t_faded;

    class fade_scoreboard;
        logic [lfgr_pkg::CFG_DATA_W-1:0] length_reg;
        logic                            fade_in_reg;
        logic                            wide_reg;
        longint                          position;
        t_faded                          faded_q[$];
        int                              errors;

        function new();
            length_reg  = lfgr_pkg::CFG_DATA_W'(1);
            fade_in_reg = 1'b1;
            wide_reg    = 1'b1;
            position    = 0;
            errors      = 0;
        endfunction

        function void set_reg(input logic [lfgr_pkg::CFG_INDEX_W-1:0] index,
                              input logic [lfgr_pkg::CFG_DATA_W-1:0] data);
            case (index)
                lfgr_pkg::CFG_FADE_LENGTH:  length_reg  = data;
                lfgr_pkg::CFG_FADE_IN:      fade_in_reg = data[0];
                lfgr_pkg::CFG_WIDE_SAMPLES: wide_reg    = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(input logic signed [lfgr_pkg::SAMPLE_W-1:0] s_in);
            longint                               len;
            longint                               idx;
            longint                               mult;
            longint                               s;
            longint                               gain;
            longint                               res;
            logic signed [lfgr_pkg::NARROW_W-1:0] narrow;
            t_faded                               item;
            len = longint'(length_reg);
            if (len == 0) len = 1;
            if (len > MAX_LEN) len = MAX_LEN;
            idx = position;
            item.last = 1'b0;
            if (idx >= len - 1) begin
                idx = len - 1;
                item.last = 1'b1;
            end
            mult = fade_in_reg ? idx : (len - idx);
            if (wide_reg) begin
                s    = longint'(s_in);
                gain = (mult * GAIN_ONE) / len;
                res  = (gain * s) / GAIN_ONE;
            end else begin
                narrow = s_in[lfgr_pkg::NARROW_W-1:0];
                s      = longint'(narrow);
                res    = (mult * s) / len;
            end
            position    = item.last ? longint'(0) : idx + 1;
            item.sample = res[lfgr_pkg::SAMPLE_W-1:0];
            faded_q.push_back(item);
        endfunction

        function void check_faded(input logic signed [lfgr_pkg::SAMPLE_W-1:0] s,
                                  input logic last);
            t_faded item;
            if (faded_q.size() == 0) begin
                errors++;
                $display("%0t unexpected item: expected none, actual sample %0d last %0b",
                         $time, s, last);
                return;
            end
            item = faded_q.pop_front();
            if (s !== item.sample) begin
                errors++;
                $display("%0t sample_out mismatch: expected %0d, actual %0d",
                         $time, item.sample, s);
            end
            if (last !== item.last) begin
                errors++;
                $display("%0t run_last mismatch: expected %0b, actual %0b",
                         $time, item.last, last);
            end
        endfunction

        function int pending();
            return faded_q.size();
        endfunction
    endclass

    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n     = 1'b0;
    logic                                   i_cfg_we    = 1'b0;
    logic [lfgr_pkg::CFG_INDEX_W-1:0]       i_cfg_index = '0;
    logic [lfgr_pkg::CFG_DATA_W-1:0]        i_cfg_data  = '0;
    logic                                   i_in_valid  = 1'b0;
    logic                                   o_in_stall;
    logic signed [lfgr_pkg::SAMPLE_W-1:0]   i_sample_in = '0;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic signed [lfgr_pkg::SAMPLE_W-1:0]   o_sample_out;
    logic                                   o_run_last;

    fade_scoreboard sb;
    int             send_idle = 36;
    int             recv_idle = 62;

    linear_fade_gain_ramp #(
        .MAX_FADE_LENGTH(MAX_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_run_last   (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_sample(i_sample_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_faded(o_sample_out, o_run_last);
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_idle);
    end

    task automatic write_reg(input logic [lfgr_pkg::CFG_INDEX_W-1:0] index,
                             input logic [lfgr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(index, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_fade(input logic [lfgr_pkg::CFG_DATA_W-1:0] len, input logic fin,
                            input logic wide);
        write_reg(lfgr_pkg::CFG_FADE_LENGTH, len);
        write_reg(lfgr_pkg::CFG_FADE_IN, lfgr_pkg::CFG_DATA_W'(fin));
        write_reg(lfgr_pkg::CFG_WIDE_SAMPLES, lfgr_pkg::CFG_DATA_W'(wide));
    endtask

    task automatic send_sample(input logic signed [lfgr_pkg::SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and let the pipeline empty before any register write
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [lfgr_pkg::SAMPLE_W-1:0] rand_sample(input logic wide);
        logic signed [lfgr_pkg::NARROW_W-1:0] narrow;
        logic [31:0]                          raw;
        int                                   pick;
        pick   = int'($urandom_range(7));
        raw    = $urandom;
        narrow = raw[lfgr_pkg::NARROW_W-1:0];
        if (pick == 0) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (wide || pick == 1) return raw[lfgr_pkg::SAMPLE_W-1:0];
        if (pick == 2) return ($urandom_range(1) != 0) ? 16'sh007F : 16'shFF80;
        return lfgr_pkg::SAMPLE_W'(narrow);
    endfunction

    function automatic logic [lfgr_pkg::CFG_DATA_W-1:0] rand_length();
        int pick;
        pick = int'($urandom_range(9));
        if (pick <= 5) return lfgr_pkg::CFG_DATA_W'($urandom_range(16, 1));
        if (pick == 6) return lfgr_pkg::CFG_DATA_W'($urandom_range(300, 17));
        if (pick == 7) return '0;
        if (pick == 8) return lfgr_pkg::CFG_DATA_W'(MAX_LEN - int'($urandom_range(1)));
        return lfgr_pkg::CFG_DATA_W'($urandom_range(2 ** lfgr_pkg::CFG_DATA_W - 1,
                                                    MAX_LEN + 1));
    endfunction

    initial begin
        logic cur_wide;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: length 1, every sample is the last with zero gain
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain();
        // zero length acts as one, fade-out passes the sample through
        set_fade('0, 1'b0, 1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'shFFFF);
        drain();
        set_fade(lfgr_pkg::CFG_DATA_W'(4), 1'b1, 1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        drain();
        // length cut below the current position
        set_fade(lfgr_pkg::CFG_DATA_W'(5), 1'b1, 1'b1);
        send_sample(16'sh03E8);
        send_sample(16'shFC18);
        send_sample(16'sh4E20);
        drain();
        write_reg(lfgr_pkg::CFG_FADE_LENGTH, lfgr_pkg::CFG_DATA_W'(2));
        send_sample(16'sh7530);
        send_sample(16'sh8AD0);
        drain();
        // 8-bit mode, high bits ignored
        set_fade(lfgr_pkg::CFG_DATA_W'(3), 1'b0, 1'b0);
        send_sample(16'sh007F);
        send_sample(16'sh0080);
        send_sample(16'sh1234);
        send_sample(16'shFF81);
        drain();
        // length above the maximum, then the maximum itself
        set_fade({lfgr_pkg::CFG_DATA_W{1'b1}}, 1'b1, 1'b0);
        send_sample(16'sh007F);
        send_sample(16'shFF80);
        drain();
        set_fade(lfgr_pkg::CFG_DATA_W'(MAX_LEN), 1'b1, 1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase / 3)
                0:       begin send_idle = 36; recv_idle = 62; end
                1:       begin send_idle = 62; recv_idle = 36; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            cur_wide = 1'($urandom_range(1));
            set_fade(rand_length(), 1'($urandom_range(1)), cur_wide);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2) begin
                    drain();
                    write_reg(lfgr_pkg::CFG_FADE_LENGTH,
                              lfgr_pkg::CFG_DATA_W'($urandom_range(8)));
                end
                send_sample(rand_sample(cur_wide));
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
